// ===== rtl/smdc_pkg.sv =====
// Shared constants and types for the stereo mixer with DC blocker.
// No dependencies; compile first.
package smdc_pkg;

   // default parameter values
   localparam int DEF_COUNT_WIDTH      = 10;
   localparam int DEF_FILTER_FRAC_BITS = 16;

   // channel and field widths
   localparam int NUM_CH     = 4;
   localparam int CH_IDX_W   = $clog2(NUM_CH);
   localparam int LEVEL_W    = 4;
   localparam int PAN_W      = 4;
   localparam int VOL_W      = 3;
   localparam int TPS_W      = 10;
   localparam int OUT_W      = 16;
   localparam int LEVEL_BIAS = 7;
   localparam int OUT_GAIN   = 50;

   // datapath widths (Q8 audio)
   localparam int AUDIO_FRAC = 8;
   localparam int SUM_W      = 16;
   localparam int DVD_W      = SUM_W + AUDIO_FRAC;
   localparam int ITER_W     = $clog2(DVD_W);
   localparam int AVG_W      = DVD_W + 1;
   localparam int MIX_W      = AVG_W + 2;
   localparam int MIXV_W     = MIX_W + VOL_W + 1;
   localparam int STATE_W    = 32;
   localparam int FSUM_W     = STATE_W + 2;
   localparam int GAIN_W     = STATE_W + 7;

   // register reset values
   localparam logic [PAN_W-1:0] PAN_RESET = 4'hF;
   localparam logic [VOL_W-1:0] VOL_RESET = 3'd7;
   localparam logic [TPS_W-1:0] TPS_RESET = 10'd95;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = TPS_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PAN_LEFT     = 3'd0,
      CSR_PAN_RIGHT    = 3'd1,
      CSR_LEFT_VOLUME  = 3'd2,
      CSR_RIGHT_VOLUME = 3'd3,
      CSR_TICKS        = 3'd4
   } csr_index_type;

endpackage

// ===== rtl/smdc_if.sv =====
// Valid/ready channel interfaces for the stereo mixer: tick input and sample output.
// Depends on smdc_pkg.
interface smdc_req_if import smdc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] ch1_level;
   logic [LEVEL_W-1:0] ch2_level;
   logic [LEVEL_W-1:0] ch3_level;
   logic [LEVEL_W-1:0] ch4_level;
   logic [NUM_CH-1:0]  dac_mask;

   modport source (output valid, ch1_level, ch2_level, ch3_level, ch4_level, dac_mask,
                   input ready);
   modport sink   (input valid, ch1_level, ch2_level, ch3_level, ch4_level, dac_mask,
                   output ready);
endinterface

interface smdc_rsp_if import smdc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] left_sample;
   logic signed [OUT_W-1:0] right_sample;

   modport source (output valid, left_sample, right_sample, input ready);
   modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

// ===== rtl/stereo_mixer_with_dc_blocker.sv =====
// Stereo mixer with per-side DC-blocking high-pass and output scaling.
// Depends on smdc_pkg and smdc_if (smdc_req_if, smdc_rsp_if).
//
// Usage:
//  - req_if carries one tick per transaction: four 4-bit channel levels and
//    the DAC enable mask. rsp_if carries one stereo sample (int16 L/R).
//  - csr_we/csr_index/csr_wdata write pan, volume and ticks_per_sample;
//    write only while no sample is in flight.
//  - A tick that does not close a sample period is only accumulated;
//    req_if.ready stays high, so such ticks stream at one per cycle.
//  - The tick that closes a period starts the mix sequencer and drops ready.
//    One shared restoring divider averages the four channel sums, one quotient
//    bit per cycle; then the filter and x50 scaling run per side through
//    S_FMUL, S_FSUM, S_GAIN and S_CLIP. The sample is put on rsp_if from
//    S_OUT (reached straight from S_VOL with all DACs off), and ready returns
//    in that same cycle.
//  - The result sits in an output register; ticks are taken while it waits.
//    If the next sample finishes before the receiver takes the previous one,
//    the sequencer holds in its last step with ready low.
//  - Reset (synchronous, active high) restores register defaults and clears
//    the accumulators, tick count, filter state and the output valid.
module stereo_mixer_with_dc_blocker import smdc_pkg::*; #(
   parameter int COUNT_WIDTH      = DEF_COUNT_WIDTH,
   parameter int FILTER_FRAC_BITS = DEF_FILTER_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   smdc_req_if.sink              req_if,
   smdc_rsp_if.source            rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // tick count plus one needs one extra bit to reach 2^COUNT_WIDTH
   localparam int N_W     = COUNT_WIDTH + 1;
   localparam int CMP_W   = (N_W > TPS_W) ? N_W : TPS_W;
   localparam int COEF_W  = FILTER_FRAC_BITS + 1;
   localparam int PROD_W  = STATE_W + COEF_W;
   localparam longint COEF_VAL =
      (996 * (longint'(1) << FILTER_FRAC_BITS) + 500) / 1000;

   typedef enum logic [3:0] {
      S_IDLE, S_LOAD, S_DIV, S_ACC, S_VOL, S_FMUL, S_FSUM, S_GAIN, S_CLIP, S_OUT
   } state_type;

   // saturate the filter sum to the 32-bit state range
   function automatic logic signed [STATE_W-1:0] sat_state(
      input logic signed [FSUM_W-1:0] v);
      logic signed [STATE_W-1:0] r;
      if (!v[FSUM_W-1] && (|v[FSUM_W-2:STATE_W-1]))
         r = {1'b0, {(STATE_W-1){1'b1}}};
      else if (v[FSUM_W-1] && !(&v[FSUM_W-2:STATE_W-1]))
         r = {1'b1, {(STATE_W-1){1'b0}}};
      else
         r = v[STATE_W-1:0];
      return r;
   endfunction

   // saturate the scaled value to int16
   function automatic logic signed [OUT_W-1:0] sat_out(
      input logic signed [GAIN_W-AUDIO_FRAC-1:0] v);
      logic signed [OUT_W-1:0] r;
      if (!v[GAIN_W-AUDIO_FRAC-1] && (|v[GAIN_W-AUDIO_FRAC-2:OUT_W-1]))
         r = {1'b0, {(OUT_W-1){1'b1}}};
      else if (v[GAIN_W-AUDIO_FRAC-1] && !(&v[GAIN_W-AUDIO_FRAC-2:OUT_W-1]))
         r = {1'b1, {(OUT_W-1){1'b0}}};
      else
         r = v[OUT_W-1:0];
      return r;
   endfunction

   // configuration registers
   logic [PAN_W-1:0] pan_left_ff, pan_right_ff;
   logic [VOL_W-1:0] left_volume_ff, right_volume_ff;
   logic [TPS_W-1:0] tps_ff;

   // sequencer and datapath registers
   state_type                  state_ff;
   logic [COUNT_WIDTH-1:0]     count_ff;
   logic signed [SUM_W-1:0]    sums_ff [NUM_CH];
   logic [N_W-1:0]             n_ff;
   logic [NUM_CH-1:0]          mask_ff;
   logic [CH_IDX_W-1:0]        ch_ff;
   logic [ITER_W-1:0]          iter_ff;
   logic [DVD_W-1:0]           dvd_ff;
   logic [N_W-1:0]             rem_ff;
   logic                       neg_ff;
   logic signed [MIX_W-1:0]    mix_l_ff, mix_r_ff;
   logic signed [STATE_W-1:0]  mixv_ff [2];
   logic signed [STATE_W-1:0]  prev_in_ff [2];
   logic signed [STATE_W-1:0]  prev_out_ff [2];
   logic                       side_ff;
   logic signed [PROD_W-1:0]   fprod_ff;
   logic signed [STATE_W-1:0]  fout_ff;
   logic signed [GAIN_W-1:0]   gain_ff;
   logic signed [OUT_W-1:0]    res_ff [2];
   logic                       rsp_valid_ff;
   logic signed [OUT_W-1:0]    rsp_left_ff, rsp_right_ff;

   // combinational next values
   logic [LEVEL_W-1:0]         levels [NUM_CH];
   logic signed [SUM_W-1:0]    sum_in [NUM_CH];
   logic [N_W-1:0]             n_in;
   logic                       fire;
   logic                       accept;
   logic signed [SUM_W-1:0]    cur_sum;
   logic [SUM_W-1:0]           abs_in;
   logic [N_W:0]               rshift;
   logic [N_W:0]               rdiff;
   logic                       qbit_in;
   logic [N_W-1:0]             rem_in;
   logic signed [AVG_W-1:0]    quot_s;
   logic signed [AVG_W-1:0]    avg_in;
   logic [VOL_W:0]             gain_l, gain_r;
   logic signed [MIXV_W-1:0]   mixv_l_in, mixv_r_in;
   logic signed [PROD_W-1:0]   coef_ext;
   logic signed [PROD_W-1:0]   fprod_in;
   logic signed [STATE_W:0]    fb;
   logic signed [FSUM_W-1:0]   fsum;
   logic signed [STATE_W-1:0]  fout_in;
   logic signed [GAIN_W-1:0]   gain_in;
   logic signed [GAIN_W-1:0]   gain_rnd;
   logic signed [GAIN_W-AUDIO_FRAC-1:0] scaled;

   assign levels[0] = req_if.ch1_level;
   assign levels[1] = req_if.ch2_level;
   assign levels[2] = req_if.ch3_level;
   assign levels[3] = req_if.ch4_level;

   assign req_if.ready        = (state_ff == S_IDLE);
   assign accept              = req_if.valid && req_if.ready;
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.left_sample  = rsp_left_ff;
   assign rsp_if.right_sample = rsp_right_ff;

   // per-tick accumulate: level minus bias for each enabled DAC, 16-bit wrap
   always_comb begin
      for (int i = 0; i < NUM_CH; i++) begin
         logic signed [LEVEL_W:0] lvl;
         lvl = $signed({1'b0, levels[i]}) - $signed((LEVEL_W+1)'(LEVEL_BIAS));
         sum_in[i] = req_if.dac_mask[i] ? sums_ff[i] + SUM_W'(lvl) : sums_ff[i];
      end
   end

   // period check: zero period acts as one, counter limit closes the period
   assign n_in = N_W'(count_ff) + N_W'(1);
   assign fire = (CMP_W'(n_in) >= CMP_W'(tps_ff)) ||
                 (n_in == {1'b1, {COUNT_WIDTH{1'b0}}});

   // divider operand load: magnitude of sum * 256
   assign cur_sum = sums_ff[ch_ff];
   assign abs_in  = cur_sum[SUM_W-1] ? SUM_W'(-cur_sum) : cur_sum;

   // restoring divider step, one quotient bit per cycle
   assign rshift  = {rem_ff, dvd_ff[DVD_W-1]};
   assign rdiff   = rshift - {1'b0, n_ff};
   assign qbit_in = (rshift >= {1'b0, n_ff});
   assign rem_in  = qbit_in ? rdiff[N_W-1:0] : rshift[N_W-1:0];

   // signed average (truncated toward zero)
   assign quot_s = $signed({1'b0, dvd_ff});
   assign avg_in = neg_ff ? -quot_s : quot_s;

   // master volume, gain is value plus one
   assign gain_l    = {1'b0, left_volume_ff} + (VOL_W+1)'(1);
   assign gain_r    = {1'b0, right_volume_ff} + (VOL_W+1)'(1);
   assign mixv_l_in = MIXV_W'(mix_l_ff) * $signed(MIXV_W'(gain_l));
   assign mixv_r_in = MIXV_W'(mix_r_ff) * $signed(MIXV_W'(gain_r));

   // high-pass: out = in - prev_in + floor(coef * prev_out >> frac)
   assign coef_ext = PROD_W'(COEF_VAL);
   assign fprod_in = PROD_W'(prev_out_ff[side_ff]) * coef_ext;
   assign fb       = fprod_ff[FILTER_FRAC_BITS +: STATE_W+1];
   assign fsum     = FSUM_W'(mixv_ff[side_ff]) - FSUM_W'(prev_in_ff[side_ff]) + FSUM_W'(fb);
   assign fout_in  = sat_state(fsum);

   // output scaling: x50, divide by 256 toward zero, clip to int16
   assign gain_in  = GAIN_W'(fout_ff) * $signed(GAIN_W'(OUT_GAIN));
   assign gain_rnd = gain_ff + (gain_ff[GAIN_W-1] ?
                     GAIN_W'((1 << AUDIO_FRAC) - 1) : GAIN_W'(0));
   assign scaled   = (GAIN_W-AUDIO_FRAC)'(gain_rnd >>> AUDIO_FRAC);

   // configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         pan_left_ff     <= PAN_RESET;
         pan_right_ff    <= PAN_RESET;
         left_volume_ff  <= VOL_RESET;
         right_volume_ff <= VOL_RESET;
         tps_ff          <= TPS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PAN_LEFT:     pan_left_ff     <= csr_wdata[PAN_W-1:0];
            CSR_PAN_RIGHT:    pan_right_ff    <= csr_wdata[PAN_W-1:0];
            CSR_LEFT_VOLUME:  left_volume_ff  <= csr_wdata[VOL_W-1:0];
            CSR_RIGHT_VOLUME: right_volume_ff <= csr_wdata[VOL_W-1:0];
            CSR_TICKS:        tps_ff          <= csr_wdata[TPS_W-1:0];
            default: ;
         endcase
      end
   end

   // tick accumulation and mix sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CH; i++) sums_ff[i] <= '0;
         for (int s = 0; s < 2; s++) begin
            prev_in_ff[s]  <= '0;
            prev_out_ff[s] <= '0;
         end
      end else begin
         // S_OUT runs the output handshake itself
         if (rsp_valid_ff && rsp_if.ready && state_ff != S_OUT) rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  for (int i = 0; i < NUM_CH; i++) sums_ff[i] <= sum_in[i];
                  if (fire) begin
                     // sums hold steady while busy; each is cleared as it is read
                     count_ff <= '0;
                     n_ff     <= n_in;
                     mask_ff  <= req_if.dac_mask;
                     ch_ff    <= '0;
                     mix_l_ff <= '0;
                     mix_r_ff <= '0;
                     state_ff <= S_LOAD;
                  end else begin
                     count_ff <= n_in[COUNT_WIDTH-1:0];
                  end
               end
            end
            S_LOAD: begin
               neg_ff         <= cur_sum[SUM_W-1];
               dvd_ff         <= {abs_in, {AUDIO_FRAC{1'b0}}};
               rem_ff         <= '0;
               iter_ff        <= '0;
               sums_ff[ch_ff] <= '0;
               state_ff       <= S_DIV;
            end
            S_DIV: begin
               dvd_ff  <= {dvd_ff[DVD_W-2:0], qbit_in};
               rem_ff  <= rem_in;
               iter_ff <= iter_ff + ITER_W'(1);
               if (iter_ff == ITER_W'(DVD_W-1)) state_ff <= S_ACC;
            end
            S_ACC: begin
               if (pan_left_ff[ch_ff])  mix_l_ff <= mix_l_ff + MIX_W'(avg_in);
               if (pan_right_ff[ch_ff]) mix_r_ff <= mix_r_ff + MIX_W'(avg_in);
               ch_ff <= ch_ff + CH_IDX_W'(1);
               if (ch_ff == CH_IDX_W'(NUM_CH-1)) state_ff <= S_VOL;
               else                               state_ff <= S_LOAD;
            end
            S_VOL: begin
               mixv_ff[0] <= STATE_W'(mixv_l_in);
               mixv_ff[1] <= STATE_W'(mixv_r_in);
               side_ff    <= 1'b0;
               if (mask_ff == '0) begin
                  // all DACs off: silence and flush the filter
                  for (int s = 0; s < 2; s++) begin
                     prev_in_ff[s]  <= '0;
                     prev_out_ff[s] <= '0;
                     res_ff[s]      <= '0;
                  end
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_FMUL;
               end
            end
            S_FMUL: begin
               fprod_ff <= fprod_in;
               state_ff <= S_FSUM;
            end
            S_FSUM: begin
               prev_in_ff[side_ff]  <= mixv_ff[side_ff];
               prev_out_ff[side_ff] <= fout_in;
               fout_ff              <= fout_in;
               state_ff             <= S_GAIN;
            end
            S_GAIN: begin
               gain_ff  <= gain_in;
               state_ff <= S_CLIP;
            end
            S_CLIP: begin
               res_ff[side_ff] <= sat_out(scaled);
               if (side_ff) begin
                  state_ff <= S_OUT;
               end else begin
                  side_ff  <= 1'b1;
                  state_ff <= S_FMUL;
               end
            end
            S_OUT: begin
               // wait for the output register to free up
               if (!rsp_valid_ff || rsp_if.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_left_ff  <= res_ff[0];
                  rsp_right_ff <= res_ff[1];
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/smdc_checker.sv =====
// Port-level assertions for the stereo mixer, attached by bind.
// Depends on smdc_pkg and stereo_mixer_with_dc_blocker.
module smdc_checker import smdc_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [OUT_W-1:0] rsp_left_sample,
   input logic signed [OUT_W-1:0] rsp_right_sample
);

   // a stalled sample stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_left_sample) &&
                                  $stable(rsp_right_sample))
      else $error("stalled sample changed or dropped");

   // a sample only appears after the block was busy mixing
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("sample without a mix pass");

   // the block goes busy only on an accepted tick
   a_busy_on_tick: assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |-> $past(req_valid))
      else $error("busy without a tick");

   // ready comes back together with the new sample
   a_ready_with_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("ready not restored with sample");

endmodule

bind stereo_mixer_with_dc_blocker smdc_checker u_smdc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_left_sample  (rsp_if.left_sample),
   .rsp_right_sample (rsp_if.right_sample)
);

// ===== verif/tb_stereo_mixer_with_dc_blocker.sv =====
`timescale 1ns / 1ps
// Self-checking bench for stereo_mixer_with_dc_blocker: directed and random ticks,
// with every sample scored against an in-bench mixer / high-pass / scaling predictor.
// Depends on smdc_pkg, smdc_if (smdc_req_if, smdc_rsp_if) and the RTL top level.
module tb_stereo_mixer_with_dc_blocker;
   import smdc_pkg::*;

   localparam int     CYCLE_LIMIT   = 1_000_000;
   localparam int     SETTLE_CYCLES = 150;     // margin for the sequencer to run out after the closing tick
   localparam int     RANDOM_TICKS  = 250;
   localparam int     MAX_REPORTS   = 10;
   localparam int     IDLE_PCT      = 16;
   localparam int     SIDE_LEFT     = 0;
   localparam int     SIDE_RIGHT    = 1;
   localparam int     FILTER_FRAC   = DEF_FILTER_FRAC_BITS;
   localparam int     PERIOD_CAP    = 1 << DEF_COUNT_WIDTH;
   localparam longint HP_COEF       = (996 * (longint'(1) << FILTER_FRAC) + 500) / 1000;
   localparam longint Q8_ONE        = longint'(1) << AUDIO_FRAC;
   localparam longint S32_MAX       = 64'sd2147483647;
   localparam longint S32_MIN       = -64'sd2147483648;
   localparam longint S16_MAX       = 64'sd32767;
   localparam longint S16_MIN       = -64'sd32768;

   localparam logic [TPS_W-1:0]     TPS_MAX      = '1;
   // indexes past the last mapped register, written to check they are ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = CSR_IDX_W'(CSR_TICKS + 1);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = '1;
   localparam int                   SPARE_COUNT  = CSR_SPARE_HI - CSR_SPARE_LO + 1;

   typedef struct packed {
      logic [NUM_CH-1:0][LEVEL_W-1:0] level;    // level[0] is channel one
      logic [NUM_CH-1:0]              dac_on;
   } tick_t;

   typedef struct packed {
      logic signed [OUT_W-1:0] left;
      logic signed [OUT_W-1:0] right;
   } sample_t;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   smdc_req_if req_if ();
   smdc_rsp_if rsp_if ();

   stereo_mixer_with_dc_blocker u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------
   // Bench bookkeeping
   // ------------------------------------------------------------------
   tick_t       pending_ticks[$];      // ticks waiting to be offered
   sample_t     expected_samples[$];   // predicted samples, oldest first
   int          ticks_queued = 0;
   int          ticks_taken  = 0;
   int          mismatches   = 0;
   int unsigned cycle_count  = 0;
   int          spare_turn   = 0;
   bit          steady       = 1'b0;   // both sides run without gaps while set

   // ------------------------------------------------------------------
   // Predictor state: register copies, channel accumulators, tick count and
   // the per-side high-pass history. Everything starts at its reset value.
   // ------------------------------------------------------------------
   logic [PAN_W-1:0]        pan_l_cfg  = PAN_RESET;
   logic [PAN_W-1:0]        pan_r_cfg  = PAN_RESET;
   logic [VOL_W-1:0]        vol_l_cfg  = VOL_RESET;
   logic [VOL_W-1:0]        vol_r_cfg  = VOL_RESET;
   logic [TPS_W-1:0]        period_cfg = TPS_RESET;
   logic signed [SUM_W-1:0] chan_acc [NUM_CH] = '{default: '0};
   int unsigned             ticks_held = 0;
   int                      hp_last_in  [2] = '{default: 0};
   int                      hp_last_out [2] = '{default: 0};

   function automatic longint clamp32(input longint v);
      if (v > S32_MAX) return S32_MAX;
      if (v < S32_MIN) return S32_MIN;
      return v;
   endfunction

   // One-pole DC blocker for one side, then x50 / 256 toward zero and int16 clip.
   // The feedback product is floored, which is what >>> does on a signed value.
   function automatic logic signed [OUT_W-1:0] dc_block(input int side, input longint x);
      longint fb;
      longint y;
      longint pcm;
      fb  = (HP_COEF * longint'(hp_last_out[side])) >>> FILTER_FRAC;
      y   = clamp32(x - longint'(hp_last_in[side]) + fb);
      hp_last_in[side]  = int'(clamp32(x));
      hp_last_out[side] = int'(y);
      pcm = (y * OUT_GAIN) / Q8_ONE;
      if (pcm > S16_MAX) pcm = S16_MAX;
      if (pcm < S16_MIN) pcm = S16_MIN;
      return pcm[OUT_W-1:0];
   endfunction

   // Applies one accepted tick to the predictor; queues a sample when the
   // tick closes a period.
   task automatic mix_tick(input tick_t t);
      int unsigned period;
      int unsigned n;
      longint      avg;
      longint      mix_l;
      longint      mix_r;
      sample_t     s;
      for (int i = 0; i < NUM_CH; i++)
         if (t.dac_on[i])
            chan_acc[i] = chan_acc[i] + SUM_W'(int'(t.level[i]) - LEVEL_BIAS);

      // a zero period behaves as one; the counter width caps the top end
      period = (period_cfg == 0) ? 1 : period_cfg;
      if (period > PERIOD_CAP) period = PERIOD_CAP;
      n = ticks_held + 1;
      if (n < period) begin
         ticks_held = n;
         return;
      end

      // a period lowered under the running count closes here, over all n ticks
      ticks_held = 0;
      mix_l = 0;
      mix_r = 0;
      for (int i = 0; i < NUM_CH; i++) begin
         avg = (longint'(chan_acc[i]) * Q8_ONE) / longint'(n);
         chan_acc[i] = '0;
         if (pan_l_cfg[i]) mix_l += avg;
         if (pan_r_cfg[i]) mix_r += avg;
      end
      mix_l *= longint'(vol_l_cfg) + 1;
      mix_r *= longint'(vol_r_cfg) + 1;

      // DAC test uses the closing tick's mask only; all off mutes and clears the filters
      if (t.dac_on != '0) begin
         s.left  = dc_block(SIDE_LEFT, mix_l);
         s.right = dc_block(SIDE_RIGHT, mix_r);
      end else begin
         s = '0;
         hp_last_in  = '{default: 0};
         hp_last_out = '{default: 0};
      end
      expected_samples.push_back(s);
   endtask

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic tick_t uniform_tick(input logic [LEVEL_W-1:0] lvl,
                                          input logic [NUM_CH-1:0]  dac);
      tick_t t;
      t.level  = {NUM_CH{lvl}};
      t.dac_on = dac;
      return t;
   endfunction

   // Levels lean toward the rails; roughly one mask in ten is all off.
   function automatic tick_t random_tick();
      tick_t t;
      for (int i = 0; i < NUM_CH; i++)
         case ($urandom_range(7))
            0:       t.level[i] = '0;
            1:       t.level[i] = '1;
            default: t.level[i] = LEVEL_W'($urandom);
         endcase
      t.dac_on = ($urandom_range(9) == 0) ? '0 : NUM_CH'($urandom_range(1, (1 << NUM_CH) - 1));
      return t;
   endfunction

   task automatic queue_tick(input tick_t t);
      pending_ticks.push_back(t);
      ticks_queued++;
   endtask

   // Drives one register write for the next edge and mirrors it in the predictor.
   task automatic write_reg(input logic [CSR_IDX_W-1:0]  idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_PAN_LEFT:     pan_l_cfg  = value[PAN_W-1:0];
         CSR_PAN_RIGHT:    pan_r_cfg  = value[PAN_W-1:0];
         CSR_LEFT_VOLUME:  vol_l_cfg  = value[VOL_W-1:0];
         CSR_RIGHT_VOLUME: vol_r_cfg  = value[VOL_W-1:0];
         CSR_TICKS:        period_cfg = value[TPS_W-1:0];
         default: ;
      endcase
   endtask

   // Full register load; junk rides above the narrow fields, and one unmapped
   // index gets a write too. Only called with the block idle.
   task automatic load_settings(input logic [PAN_W-1:0] pl, input logic [PAN_W-1:0] pr,
                                input logic [VOL_W-1:0] vl, input logic [VOL_W-1:0] vr,
                                input logic [TPS_W-1:0] tps);
      logic [CSR_DATA_W-1:0] junk;
      junk = CSR_DATA_W'($urandom);
      write_reg(CSR_PAN_LEFT,     {junk[CSR_DATA_W-1:PAN_W], pl});
      write_reg(CSR_PAN_RIGHT,    {junk[CSR_DATA_W-1:PAN_W], pr});
      write_reg(CSR_LEFT_VOLUME,  {junk[CSR_DATA_W-1:VOL_W], vl});
      write_reg(CSR_RIGHT_VOLUME, {junk[CSR_DATA_W-1:VOL_W], vr});
      write_reg(CSR_TICKS,        tps);
      write_reg(CSR_SPARE_LO + CSR_IDX_W'(spare_turn % SPARE_COUNT), ~junk);
      spare_turn++;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Wait until every tick is taken and every sample is back, then let the
   // sequencer run out before anything touches the registers.
   task automatic settle();
      while (ticks_taken != ticks_queued || expected_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic void note_fault(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch %0d at cycle %0d: %s", mismatches, cycle_count, msg);
   endfunction

   // ------------------------------------------------------------------
   // Tick driver: offers the head of pending_ticks, keeps a stalled
   // transaction stable, and feeds the predictor on every accepted one.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : tick_driver
      tick_t head;
      if (reset) begin
         req_if.valid     <= 1'b0;
         req_if.ch1_level <= '0;
         req_if.ch2_level <= '0;
         req_if.ch3_level <= '0;
         req_if.ch4_level <= '0;
         req_if.dac_mask  <= '0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            mix_tick(pending_ticks.pop_front());
            ticks_taken++;
         end
         // a transaction left waiting on ready stays on the bus untouched
         if (!req_if.valid || req_if.ready) begin
            if (pending_ticks.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
               head = pending_ticks[0];
               req_if.valid     <= 1'b1;
               req_if.ch1_level <= head.level[0];
               req_if.ch2_level <= head.level[1];
               req_if.ch3_level <= head.level[2];
               req_if.ch4_level <= head.level[3];
               req_if.dac_mask  <= head.dac_on;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Sample monitor: scores each accepted sample against the oldest
   // prediction and throttles ready at random.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : sample_monitor
      sample_t got;
      sample_t want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.left  = rsp_if.left_sample;
            got.right = rsp_if.right_sample;
            if (expected_samples.size() == 0) begin
               note_fault($sformatf("sample with nothing pending: L=%0d R=%0d",
                                    got.left, got.right));
            end else begin
               want = expected_samples.pop_front();
               if (got.left !== want.left)
                  note_fault($sformatf("left_sample expected %0d got %0d",
                                       want.left, got.left));
               if (got.right !== want.right)
                  note_fault($sformatf("right_sample expected %0d got %0d",
                                       want.right, got.right));
            end
         end
         rsp_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      tick_t t;
      int    phase;
      int    burst;
      int    issued;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // --- Directed: one sample per tick, rails and single channels ---
      load_settings(PAN_RESET, PAN_RESET, VOL_RESET, VOL_RESET, TPS_W'(1));
      queue_tick(uniform_tick('0, '1));          // most negative mix
      queue_tick(uniform_tick('1, '1));          // full swing up
      queue_tick(uniform_tick('1, '0));          // all DACs off: mute, filters cleared
      queue_tick(uniform_tick('1, '1));          // filter restarts from zero
      queue_tick(uniform_tick('0, 4'b0001));
      queue_tick(uniform_tick('1, 4'b0010));
      queue_tick(uniform_tick('0, 4'b0100));
      queue_tick(uniform_tick('1, 4'b1000));
      t = uniform_tick('0, '1);
      t.level[1] = '1;
      t.level[3] = '1;
      queue_tick(t);
      settle();

      // zero period acts as one; uneven panning and volumes
      load_settings(4'h5, 4'hA, 3'd0, 3'd3, '0);
      queue_tick(uniform_tick('1, '1));
      queue_tick(uniform_tick('0, '1));
      queue_tick(random_tick());
      settle();

      // two-tick period: DACs on while summing, off on the closing tick
      load_settings(PAN_RESET, PAN_RESET, VOL_RESET, VOL_RESET, TPS_W'(2));
      queue_tick(uniform_tick('1, '1));
      queue_tick(uniform_tick('1, '0));
      queue_tick(uniform_tick('0, '1));
      queue_tick(uniform_tick(4'd9, 4'b0011));
      settle();

      // period lowered under the running count: next tick closes over 5 ticks
      load_settings(4'hF, 4'h3, 3'd7, 3'd0, TPS_W'(6));
      repeat (4) queue_tick(random_tick());
      settle();
      load_settings(4'hF, 4'h3, 3'd7, 3'd0, TPS_W'(3));
      queue_tick(random_tick());
      settle();

      // --- Random phases, mostly short periods so samples come often ---
      phase  = 0;
      issued = 0;
      while (issued < RANDOM_TICKS) begin
         case (phase)
            0:       load_settings('1, '1, '1, '1, TPS_W'(1));      // widest gain
            1:       load_settings('0, '0, '0, '0, TPS_W'($urandom_range(0, 4)));
            default: load_settings(PAN_W'($urandom), PAN_W'($urandom),
                                   VOL_W'($urandom), VOL_W'($urandom),
                                   ($urandom_range(3) == 0) ? TPS_W'($urandom_range(11, 60))
                                                            : TPS_W'($urandom_range(0, 10)));
         endcase
         steady = (phase == 2);
         burst  = steady ? 200 : $urandom_range(20, 120);
         repeat (burst) queue_tick(random_tick());
         issued += burst;
         settle();
         steady = 1'b0;
         phase++;
      end

      // --- Longest period: one full 1023-tick sample with loud, mostly high levels ---
      load_settings('1, '1, '1, '1, TPS_MAX);
      burst = int'(TPS_MAX) - int'(ticks_held) + 4;
      repeat (burst) begin
         t = random_tick();
         if ($urandom_range(3) != 0) t = uniform_tick('1, '1);
         queue_tick(t);
      end
      settle();

      if (mismatches == 0 && expected_samples.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
